FILE: design/ilm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilm_pkg
// Shared types, codes and helpers for the logistic marginals block.
// ---------------------------------------------------------------------------
package ilm_pkg;

   localparam int DefNumFeatures   = 16;
   localparam int DefNumDims       = 4;
   localparam int DefNumCategories = 4;

   localparam int KindW  = 3;
   localparam int DimW   = 2;
   localparam int SlotW  = 4;
   localparam int ValW   = 16;
   localparam int AccW   = 40;
   localparam int ProbW  = 16;

   typedef enum logic [KindW-1:0] {
      KIND_WEIGHT  = 3'd0,
      KIND_BIAS    = 3'd1,
      KIND_LOG_OUT = 3'd2,
      KIND_LOG_IN  = 3'd3,
      KIND_FEATURE = 3'd4,
      KIND_OBSERVE = 3'd5,
      KIND_SPARE6  = 3'd6,
      KIND_SPARE7  = 3'd7
   } kind_type;

   localparam logic RESULT_MARGINAL = 1'b0;
   localparam logic RESULT_PAIR     = 1'b1;

   // Datapath commands from the controller.
   typedef enum logic [2:0] {
      CMD_NONE    = 3'd0,
      CMD_LOAD    = 3'd1,  // apply the taken item to its store
      CMD_MAC     = 3'd2,  // one feature product into dimension dim_a
      CMD_SCORE   = 3'd3,  // finish dimension dim_a: sigmoid, clear
      CMD_PAIR_MUL = 3'd4, // multiply marginals dim_a, dim_b
      CMD_EMIT_M  = 3'd5,  // load output with marginal dim_a
      CMD_EMIT_P  = 3'd6   // load output with pair product
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type op;
      logic [7:0]   dim_a;
      logic [7:0]   dim_b;
      logic         last_result;
   } ctl_cmd_type;

   // Piecewise-linear sigmoid on a Q.16 score, saturated to Q0.16.
   function automatic logic [ProbW-1:0] sigmoid_q16(input logic signed [AccW+1:0] s);
      logic [AccW+1:0] a;
      logic [AccW+1:0] y;
      a = s[AccW+1] ? (~s + 1'b1) : s;
      if (a >= (AccW+2)'(5 * 65536))     y = (AccW+2)'(65536);
      else if (a >= (AccW+2)'(155648))   y = (a >> 5) + (AccW+2)'(55296);
      else if (a >= (AccW+2)'(65536))    y = (a >> 3) + (AccW+2)'(40960);
      else                               y = (a >> 2) + (AccW+2)'(32768);
      if (s[AccW+1]) y = (AccW+2)'(65536) - y;
      if (y > (AccW+2)'(65535)) y = (AccW+2)'(65535);
      return y[ProbW-1:0];
   endfunction

endpackage
`default_nettype wire

FILE: design/ilm_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilm_datapath
// Stores, shared multiply-accumulate, sigmoid and pair multiplier.
// ---------------------------------------------------------------------------
module ilm_datapath #(
   parameter int NUM_FEATURES   = ilm_pkg::DefNumFeatures,
   parameter int NUM_DIMS       = ilm_pkg::DefNumDims,
   parameter int NUM_CATEGORIES = ilm_pkg::DefNumCategories
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ilm_pkg::ctl_cmd_type       cmd,
   input  wire logic [ilm_pkg::KindW-1:0]  item_kind,
   input  wire logic [ilm_pkg::DimW-1:0]   item_dim,
   input  wire logic [ilm_pkg::SlotW-1:0]  item_slot,
   input  wire logic signed [ilm_pkg::ValW-1:0] item_value,
   input  wire logic                       item_observed,
   input  wire logic                       posterior_mode,
   output logic                            out_kind,
   output logic [ilm_pkg::DimW-1:0]        out_first,
   output logic [ilm_pkg::DimW-1:0]        out_second,
   output logic [ilm_pkg::ProbW-1:0]       out_prob,
   output logic                            out_last
);
   import ilm_pkg::*;

   localparam int CW = (NUM_CATEGORIES > 1) ? $clog2(NUM_CATEGORIES) : 1;
   localparam int DW = (NUM_DIMS > 1) ? $clog2(NUM_DIMS) : 1;

   logic signed [ValW-1:0] weight_mem [NUM_DIMS*NUM_FEATURES];
   logic signed [ValW-1:0] bias_ff    [NUM_DIMS];
   logic signed [ValW-1:0] lout_ff    [NUM_DIMS*NUM_CATEGORIES];
   logic signed [ValW-1:0] lin_ff     [NUM_DIMS*NUM_CATEGORIES];
   logic [AccW-1:0]        acc_ff     [NUM_DIMS];
   logic                   obs_ff     [NUM_DIMS];
   logic [SlotW-1:0]       cat_ff     [NUM_DIMS];
   logic [ProbW-1:0]       marg_ff    [NUM_DIMS];
   logic [2*ProbW-1:0]     pair_ff;
   logic signed [ValW-1:0] wrd_ff;

   logic [DW-1:0] da, db;
   logic [DW-1:0] rd_dim;
   logic          dim_ok, feat_ok, cat_ok;
   logic signed [2*ValW-1:0] prod;
   logic signed [AccW+1:0] score;
   logic [CW-1:0] cat_idx;
   logic          use_em;
   logic [2*ProbW:0] pair_rnd;

   assign da      = cmd.dim_a[DW-1:0];
   assign db      = cmd.dim_b[DW-1:0];
   assign dim_ok  = 32'(item_dim) < NUM_DIMS;
   assign feat_ok = 32'(item_slot) < NUM_FEATURES;
   assign cat_ok  = 32'(item_slot) < NUM_CATEGORIES;
   assign cat_idx = cat_ff[da][CW-1:0];

   // Fetch the weight one dimension ahead of the MAC that uses it.
   assign rd_dim = (cmd.op == CMD_MAC && 32'(da) != NUM_DIMS-1) ? da + 1'b1 : '0;

   // Feature product, score and pair rounding.
   always_comb begin
      prod = item_value * wrd_ff;
      use_em = posterior_mode && obs_ff[da] && (32'(cat_ff[da]) < NUM_CATEGORIES);
      score = (AccW+2)'($signed(acc_ff[da])) + ((AccW+2)'(bias_ff[da]) <<< 8);
      if (use_em) begin
         score = score
            + ((AccW+2)'(lout_ff[32'(da)*NUM_CATEGORIES + 32'(cat_idx)]) <<< 8)
            - ((AccW+2)'(lin_ff[32'(da)*NUM_CATEGORIES + 32'(cat_idx)]) <<< 8);
      end
      pair_rnd = {1'b0, pair_ff} + (2*ProbW+1)'(32768);
   end

   // Stores, registered weight read and pair product.
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_LOAD && dim_ok) begin
         unique case (kind_type'(item_kind))
            KIND_WEIGHT: if (feat_ok)
               weight_mem[32'(item_dim)*NUM_FEATURES + 32'(item_slot)] <= item_value;
            KIND_BIAS: bias_ff[item_dim[DW-1:0]] <= item_value;
            KIND_LOG_OUT: if (cat_ok)
               lout_ff[32'(item_dim)*NUM_CATEGORIES + 32'(item_slot[CW-1:0])] <= item_value;
            KIND_LOG_IN: if (cat_ok)
               lin_ff[32'(item_dim)*NUM_CATEGORIES + 32'(item_slot[CW-1:0])] <= item_value;
            default: ;
         endcase
      end
      wrd_ff <= weight_mem[32'(rd_dim)*NUM_FEATURES + 32'(item_slot)];
      if (cmd.op == CMD_PAIR_MUL) pair_ff <= marg_ff[da] * marg_ff[db];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_DIMS; i++) begin
            acc_ff[i]  <= '0;
            obs_ff[i]  <= 1'b0;
            cat_ff[i]  <= '0;
            marg_ff[i] <= '0;
         end
      end else begin
         if (cmd.op == CMD_LOAD && dim_ok &&
             kind_type'(item_kind) == KIND_OBSERVE) begin
            obs_ff[item_dim[DW-1:0]] <= item_observed;
            cat_ff[item_dim[DW-1:0]] <= item_observed ? item_slot : '0;
         end
         if (cmd.op == CMD_MAC && feat_ok) acc_ff[da] <= acc_ff[da] + AccW'(prod);
         if (cmd.op == CMD_SCORE) begin
            marg_ff[da] <= sigmoid_q16(score);
            acc_ff[da]  <= '0;
            obs_ff[da]  <= 1'b0;
            cat_ff[da]  <= '0;
         end
      end
   end

   // Output payload register.
   always_ff @(posedge clock) begin
      if (cmd.op == CMD_EMIT_M) begin
         out_kind   <= RESULT_MARGINAL;
         out_first  <= DimW'(da);
         out_second <= DimW'(da);
         out_prob   <= marg_ff[da];
         out_last   <= cmd.last_result;
      end else if (cmd.op == CMD_EMIT_P) begin
         out_kind   <= RESULT_PAIR;
         out_first  <= DimW'(da);
         out_second <= DimW'(db);
         out_prob   <= pair_rnd[2*ProbW-1:ProbW];
         out_last   <= cmd.last_result;
      end
   end
endmodule
`default_nettype wire

FILE: design/ilm_control.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ilm_control
// Sequencer: item capture, per-dimension MAC, scoring and result emission.
// ---------------------------------------------------------------------------
module ilm_control #(
   parameter int NUM_DIMS = ilm_pkg::DefNumDims
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [ilm_pkg::KindW-1:0] req_kind,
   input  wire logic                 req_last,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output ilm_pkg::ctl_cmd_type      cmd
);
   import ilm_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_SCORE, ST_MARG, ST_MUL, ST_PAIR, ST_WAIT
   } state_type;

   state_type state_ff, state_in;
   logic [7:0] a_ff, a_in, b_ff, b_in;
   logic       last_ff, last_in;
   logic       pend_ff, pend_in;   // beat held in output register
   logic       nextp_ff, nextp_in; // state after the wait
   logic       take;

   assign req_ready = (state_ff == ST_IDLE);
   assign take      = req_valid && req_ready;
   assign rsp_valid = pend_ff;

   always_comb begin
      state_in = state_ff; a_in = a_ff; b_in = b_ff; last_in = last_ff;
      pend_in = pend_ff; nextp_in = nextp_ff;
      cmd = '{op: CMD_NONE, dim_a: a_ff, dim_b: b_ff, last_result: 1'b0};
      if (pend_ff && rsp_ready) pend_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: if (take) begin
            cmd.op = CMD_LOAD;
            last_in = req_last;
            a_in = '0;
            if (kind_type'(req_kind) == KIND_FEATURE) state_in = ST_MAC;
            else if (req_last) state_in = ST_SCORE;
         end
         ST_MAC: begin
            cmd.op = CMD_MAC;
            if (32'(a_ff) == NUM_DIMS-1) begin
               a_in = '0;
               state_in = last_ff ? ST_SCORE : ST_IDLE;
            end else a_in = a_ff + 8'd1;
         end
         ST_SCORE: begin
            cmd.op = CMD_SCORE;
            if (32'(a_ff) == NUM_DIMS-1) begin
               a_in = '0; state_in = ST_MARG;
            end else a_in = a_ff + 8'd1;
         end
         ST_MARG: if (!pend_ff || rsp_ready) begin
            cmd.op = CMD_EMIT_M;
            cmd.last_result = (NUM_DIMS == 1);
            pend_in = 1'b1;
            if (32'(a_ff) == NUM_DIMS-1) begin
               if (NUM_DIMS == 1) state_in = ST_IDLE;
               else begin a_in = '0; b_in = 8'd1; state_in = ST_MUL; end
            end else a_in = a_ff + 8'd1;
         end
         ST_MUL: begin
            cmd.op = CMD_PAIR_MUL;
            state_in = ST_PAIR;
         end
         ST_PAIR: if (!pend_ff || rsp_ready) begin
            cmd.op = CMD_EMIT_P;
            cmd.last_result = (32'(a_ff) == NUM_DIMS-2) && (32'(b_ff) == NUM_DIMS-1);
            pend_in = 1'b1;
            if (cmd.last_result) state_in = ST_IDLE;
            else begin
               state_in = ST_MUL;
               if (32'(b_ff) == NUM_DIMS-1) begin
                  a_in = a_ff + 8'd1; b_in = a_ff + 8'd2;
               end else b_in = b_ff + 8'd1;
            end
         end
         ST_WAIT: state_in = nextp_ff ? ST_PAIR : ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE; a_ff <= '0; b_ff <= '0;
         last_ff <= 1'b0; pend_ff <= 1'b0; nextp_ff <= 1'b0;
      end else begin
         state_ff <= state_in; a_ff <= a_in; b_ff <= b_in;
         last_ff <= last_in; pend_ff <= pend_in; nextp_ff <= nextp_in;
      end
   end
endmodule
`default_nettype wire

FILE: design/independent_logistic_marginals.sv
`default_nettype none
// ---------------------------------------------------------------------------
// independent_logistic_marginals
// Per-dimension logistic scores with sigmoid marginals and pair products.
// ---------------------------------------------------------------------------
// Load and observation items are applied when taken. A feature item runs
// through the single shared multiply-accumulate, which visits one
// dimension per cycle. A sample's closing item then scores all NUM_DIMS
// dimensions, then gives NUM_DIMS marginal beats at one per cycle while
// rsp_ready is high, and NUM_DIMS*(NUM_DIMS-1)/2 pair beats, each through
// the one shared multiplier and then the output register, all stalled
// by rsp_ready. The next item may be taken while the sample's final beat
// waits in the output register.
module independent_logistic_marginals #(
   parameter int NUM_FEATURES   = ilm_pkg::DefNumFeatures,
   parameter int NUM_DIMS       = ilm_pkg::DefNumDims,
   parameter int NUM_CATEGORIES = ilm_pkg::DefNumCategories
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_posterior_mode,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_kind,
   input  wire logic [1:0]  req_dim_index,
   input  wire logic [3:0]  req_slot_index,
   input  wire logic signed [15:0] req_value,
   input  wire logic        req_observed,
   input  wire logic        req_last,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_result_kind,
   output logic [1:0]       rsp_first_dim,
   output logic [1:0]       rsp_second_dim,
   output logic [15:0]      rsp_probability,
   output logic             rsp_last_result
);
   import ilm_pkg::*;

   ctl_cmd_type cmd;
   logic        mode_ff;
   logic [2:0]  kind_ff;
   logic [1:0]  dim_ff;
   logic [3:0]  slot_ff;
   logic signed [15:0] value_ff;
   logic        obs_ff;
   logic        take;

   assign csr_ready = 1'b1;
   assign take = req_valid && req_ready;

   // Hold the mode register.
   always_ff @(posedge clock) begin
      if (reset) mode_ff <= 1'b0;
      else if (csr_valid) mode_ff <= csr_posterior_mode;
   end

   // Register each taken item so a feature item stays held for the MAC.
   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff <= req_kind; dim_ff <= req_dim_index; slot_ff <= req_slot_index;
         value_ff <= req_value; obs_ff <= req_observed;
      end
   end

   logic [2:0]  dp_kind;
   logic [1:0]  dp_dim;
   logic [3:0]  dp_slot;
   logic signed [15:0] dp_value;
   logic        dp_obs;
   assign dp_kind  = take ? req_kind : kind_ff;
   assign dp_dim   = take ? req_dim_index : dim_ff;
   assign dp_slot  = take ? req_slot_index : slot_ff;
   assign dp_value = take ? req_value : value_ff;
   assign dp_obs   = take ? req_observed : obs_ff;

   ilm_control #(.NUM_DIMS(NUM_DIMS)) u_ctl (
      .clock, .reset, .req_valid, .req_ready, .req_kind, .req_last,
      .rsp_valid, .rsp_ready, .cmd
   );

   ilm_datapath #(
      .NUM_FEATURES(NUM_FEATURES), .NUM_DIMS(NUM_DIMS),
      .NUM_CATEGORIES(NUM_CATEGORIES)
   ) u_dp (
      .clock, .reset, .cmd,
      .item_kind(dp_kind), .item_dim(dp_dim), .item_slot(dp_slot),
      .item_value(dp_value), .item_observed(dp_obs), .posterior_mode(mode_ff),
      .out_kind(rsp_result_kind), .out_first(rsp_first_dim),
      .out_second(rsp_second_dim), .out_prob(rsp_probability),
      .out_last(rsp_last_result)
   );

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_probability) &&
         $stable(rsp_first_dim) && $stable(rsp_second_dim) &&
         $stable(rsp_result_kind) && $stable(rsp_last_result)))
      else $error("result beat dropped or changed while stalled");
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_result_kind) |-> (rsp_first_dim < rsp_second_dim))
      else $error("pair dims out of order");
   a_marg_dims: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_result_kind) |-> (rsp_first_dim == rsp_second_dim))
      else $error("marginal dims differ");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_independent_logistic_marginals.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_independent_logistic_marginals
// Loads weights, biases and emission tables, streams samples of features and
// observations, and checks every marginal and pair product beat against a
// local fixed-point predictor, in both scoring modes.
// ---------------------------------------------------------------------------

import ilm_pkg::*;

class marginal_scoreboard;
   typedef struct packed {
      logic        rkind;
      logic [1:0]  d1;
      logic [1:0]  d2;
      logic [15:0] prob;
      logic        lastr;
   } beat_type;

   logic signed [15:0] weights [64];
   logic signed [15:0] biases [4];
   logic signed [15:0] log_out [16];
   logic signed [15:0] log_in [16];
   logic [39:0]        scores [4];
   logic [4:0]         obs_regs [4];
   logic [15:0]        marg [4];
   bit                 posterior;
   beat_type           pending [$];
   int                 errors;

   function new();
      foreach (scores[d]) begin
         scores[d] = '0;
         obs_regs[d] = '0;
         marg[d] = '0;
      end
      foreach (weights[i]) weights[i] = '0;
      foreach (biases[i]) biases[i] = '0;
      foreach (log_out[i]) begin
         log_out[i] = '0;
         log_in[i] = '0;
      end
      posterior = 0;
      errors = 0;
   endfunction

   function logic [15:0] squash(logic signed [41:0] s);
      logic [41:0] a;
      logic [41:0] y;
      a = s < 0 ? -s : s;
      if (a >= 42'd327680) y = 42'd65536;
      else if (a >= 42'd155648) y = (a >> 5) + 42'd55296;
      else if (a >= 42'd65536) y = (a >> 3) + 42'd40960;
      else y = (a >> 2) + 42'd32768;
      if (s < 0) y = 42'd65536 - y;
      if (y > 42'd65535) y = 42'd65535;
      return y[15:0];
   endfunction

   // Apply one accepted item and queue the beats it produces.
   function void note_item(logic [2:0] kind, logic [1:0] dim, logic [3:0] slot,
                           logic signed [15:0] val, logic obs, logic lst);
      logic signed [41:0] s;
      logic signed [31:0] prod;
      logic [31:0]        pp;
      beat_type           b;
      case (kind)
         KIND_WEIGHT:  weights[dim * 16 + slot] = val;
         KIND_BIAS:    biases[dim] = val;
         KIND_LOG_OUT: if (slot < 4) log_out[dim * 4 + slot] = val;
         KIND_LOG_IN:  if (slot < 4) log_in[dim * 4 + slot] = val;
         KIND_FEATURE: begin
            for (int d = 0; d < 4; d++) begin
               prod = val * weights[d * 16 + slot];
               scores[d] = scores[d] + {{8{prod[31]}}, prod};
            end
         end
         KIND_OBSERVE: obs_regs[dim] = obs ? {1'b1, slot} : 5'd0;
         default: ;
      endcase
      if (!lst) return;
      for (int d = 0; d < 4; d++) begin
         s = $signed(scores[d]) + $signed(biases[d]) * 256;
         if (posterior && obs_regs[d][4] && obs_regs[d][3:0] < 4)
            s = s + ($signed(log_out[d * 4 + obs_regs[d][1:0]])
                     - $signed(log_in[d * 4 + obs_regs[d][1:0]])) * 256;
         marg[d] = squash(s);
         scores[d] = '0;
         obs_regs[d] = '0;
      end
      for (int d = 0; d < 4; d++) begin
         b = '{RESULT_MARGINAL, d[1:0], d[1:0], marg[d], 1'b0};
         pending.push_back(b);
      end
      for (int d = 0; d < 4; d++)
         for (int e = d + 1; e < 4; e++) begin
            pp = (marg[d] * marg[e] + 32'd32768) >> 16;
            b = '{RESULT_PAIR, d[1:0], e[1:0], pp[15:0], (d == 2 && e == 3)};
            pending.push_back(b);
         end
   endfunction

   // Compare one result beat with the oldest expectation.
   function void check_beat(logic rk, logic [1:0] d1, logic [1:0] d2,
                            logic [15:0] p, logic lr);
      beat_type x;
      if (pending.size() == 0) begin
         $error("unexpected result beat");
         errors++;
         return;
      end
      x = pending.pop_front();
      if (rk !== x.rkind) begin
         $error("result_kind exp %0d got %0d", x.rkind, rk); errors++;
      end
      if (d1 !== x.d1) begin
         $error("first_dim exp %0d got %0d", x.d1, d1); errors++;
      end
      if (d2 !== x.d2) begin
         $error("second_dim exp %0d got %0d", x.d2, d2); errors++;
      end
      if (p !== x.prob) begin
         $error("probability exp %0d got %0d", x.prob, p); errors++;
      end
      if (lr !== x.lastr) begin
         $error("last_result exp %0d got %0d", x.lastr, lr); errors++;
      end
   endfunction
endclass

module tb_independent_logistic_marginals;
   logic clock = 0;
   logic reset = 1;
   logic csr_valid = 0;
   logic csr_posterior_mode = 0;
   logic req_valid = 0;
   logic [2:0] req_kind = '0;
   logic [1:0] req_dim_index = '0;
   logic [3:0] req_slot_index = '0;
   logic signed [15:0] req_value = '0;
   logic req_observed = 0;
   logic req_last = 0;
   logic rsp_ready = 0;
   wire csr_ready, req_ready, rsp_valid, rsp_result_kind, rsp_last_result;
   wire [1:0] rsp_first_dim, rsp_second_dim;
   wire [15:0] rsp_probability;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_off = 0;
   marginal_scoreboard board;

   independent_logistic_marginals DUT (.*);

   always #5 clock = ~clock;

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   // Receiver: random stalls, plus one long hold-off on request.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         board.check_beat(rsp_result_kind, rsp_first_dim, rsp_second_dim,
                          rsp_probability, rsp_last_result);
      rsp_ready <= !reset && !hold_off && ($urandom_range(99) >= recv_idle_pct);
   end

   // Offer one beat; valid stays high into the next call unless the sender idles.
   task automatic send_item(logic [2:0] kind, logic [1:0] dim, logic [3:0] slot,
                            logic [15:0] val, logic obs, logic lst);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_dim_index <= dim;
      req_slot_index <= slot;
      req_value <= val;
      req_observed <= obs;
      req_last <= lst;
      do @(posedge clock); while (!req_ready);
      board.note_item(kind, dim, slot, val, obs, lst);
   endtask

   task automatic write_mode(logic mode);
      req_valid <= 0;
      csr_valid <= 1;
      csr_posterior_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      board.posterior = mode;
      csr_valid <= 0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_valid <= 0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (40) @(posedge clock);
   endtask

   // Load every store entry so no read ever sees an unwritten one.
   task automatic load_all(bit extreme);
      logic [15:0] v;
      for (int d = 0; d < 4; d++) begin
         for (int f = 0; f < 16; f++) begin
            v = extreme ? ((f % 2) ? 16'h7fff : 16'h8000) : 16'($urandom_range(0, 511) - 256);
            send_item(KIND_WEIGHT, 2'(d), 4'(f), v, 0, 0);
         end
         send_item(KIND_BIAS, 2'(d), 0, 16'($urandom_range(0, 1023) - 512), 0, 0);
         for (int c = 0; c < 4; c++) begin
            send_item(KIND_LOG_OUT, 2'(d), 4'(c), 16'($urandom_range(0, 1023) - 512), 0, 0);
            send_item(KIND_LOG_IN, 2'(d), 4'(c), 16'($urandom_range(0, 1023) - 512), 0, 0);
         end
      end
   endtask

   // One sample: features, observations, occasional noise, closing item.
   task automatic send_sample();
      int n;
      n = $urandom_range(0, 6);
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: send_item(KIND_OBSERVE, 2'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom), 0);
            1: send_item(KIND_OBSERVE, 2'($urandom), 4'($urandom_range(0, 3)),
                         16'($urandom), 1, 0);
            2: send_item(3'($urandom_range(6, 7)), 2'($urandom), 4'($urandom),
                         16'($urandom), 1'($urandom), 0);
            3: send_item(KIND_BIAS, 2'($urandom), 4'($urandom),
                         16'($urandom_range(0, 1023) - 512), 1'($urandom), 0);
            4: send_item(KIND_LOG_OUT, 2'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom), 0);
            5: send_item(KIND_WEIGHT, 2'($urandom), 4'($urandom), 16'($urandom),
                         1'($urandom), 0);
            default: send_item(KIND_FEATURE, 2'($urandom), 4'($urandom), 16'($urandom),
                               1'($urandom), 0);
         endcase
      end
      send_item(3'($urandom_range(4, 7)), 2'($urandom), 4'($urandom), 16'($urandom),
                1'($urandom), 1);
   endtask

   task automatic random_phase(int samples);
      for (int i = 0; i < samples; i++) send_sample();
      drain();
   endtask

   initial begin
      board = new();
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: extremes and most kinds, closing with observe, bias, spare, weight and log-in items.
      write_mode(1);
      load_all(1);
      send_item(KIND_FEATURE, 0, 15, 16'h7fff, 0, 0);
      send_item(KIND_FEATURE, 0, 0, 16'h8000, 0, 0);
      send_item(KIND_OBSERVE, 1, 3, 0, 1, 0);
      send_item(KIND_OBSERVE, 2, 9, 0, 1, 0);
      send_item(KIND_OBSERVE, 3, 1, 0, 1, 0);
      send_item(KIND_OBSERVE, 3, 1, 0, 0, 0);
      send_item(KIND_OBSERVE, 0, 2, 0, 1, 1);
      send_item(KIND_BIAS, 0, 0, 16'h7fff, 0, 0);
      send_item(KIND_BIAS, 1, 0, 16'h8000, 0, 1);
      send_item(KIND_SPARE6, 0, 0, 0, 0, 1);
      send_item(KIND_WEIGHT, 2, 5, 16'h0100, 0, 1);
      send_item(KIND_LOG_IN, 2, 8, 16'h1234, 0, 1);
      drain();

      // Normal tables, mode off then on; sender idles more lightly, then heavily.
      load_all(0);
      write_mode(0);
      send_idle_pct = 28; recv_idle_pct = 56;
      random_phase(18);
      write_mode(1);
      send_idle_pct = 56; recv_idle_pct = 28;
      random_phase(18);

      // Fill the block while the receiver holds off.
      send_idle_pct = 0; recv_idle_pct = 0;
      fork
         begin
            hold_off = 1;
            repeat (400) @(posedge clock);
            hold_off = 0;
         end
         random_phase(6);
      join
      write_mode(0);
      random_phase(9);
      write_mode(1);
      random_phase(9);

      if (board.errors == 0 && board.pending.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

FILE: independent_logistic_marginals.f
design/ilm_pkg.sv
design/ilm_datapath.sv
design/ilm_control.sv
design/independent_logistic_marginals.sv
tb/tb_independent_logistic_marginals.sv
